FILE: hdl/tickless_wakeup_timer_control_top_defines.svh
// ----------------------------------------------------------------------------
// Tickless wakeup timer control assertion macros
// Property templates shared by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TICKLESS_WAKEUP_TIMER_CONTROL_TOP_DEFINES_SVH
`define TICKLESS_WAKEUP_TIMER_CONTROL_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWTC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/twtc_pkg.sv
// ----------------------------------------------------------------------------
// Tickless wakeup timer control package
// Widths, request codes, register indexes and settle modes.
// ----------------------------------------------------------------------------
package twtc_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned MODE_W = 3;

	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WAKE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_TICK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_IRQ = 1'd1;

	localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PLAN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EARLY = 3'd4;

	typedef logic [DATA_W-1:0] word_t;

endpackage

FILE: hdl/tickless_wakeup_timer_control_top.sv
// ----------------------------------------------------------------------------
// Tickless wakeup timer control
// Plans a tickless sleep and settles the tick account when the sleep ends.
// ----------------------------------------------------------------------------
// One beat is handled at a time. A start that plans a sleep runs the shared
// one-bit-per-cycle restoring divider, then the multiplier state and then the
// finishing state. An early wakeup takes the same steps, with the multiply
// before the divide. All other requests go straight to the finishing state.
// The finishing state waits while the output register still holds an untaken
// beat. The input is ready again once the result sits in the output register.
`include "tickless_wakeup_timer_control_top_defines.svh"

module tickless_wakeup_timer_control_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [twtc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twtc_pkg::DATA_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [twtc_pkg::REQ_W-1:0]     req_type,
	input  logic [twtc_pkg::DATA_W-1:0]    sleep_request,
	input  logic [twtc_pkg::DATA_W-1:0]    timer_before,
	input  logic [twtc_pkg::DATA_W-1:0]    timer_now,
	input  logic [twtc_pkg::DATA_W-1:0]    irq_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          reload_valid,
	output logic [twtc_pkg::DATA_W-1:0]    reload_cycles,
	output logic [twtc_pkg::DATA_W-1:0]    ticks_to_add,
	output logic [twtc_pkg::DATA_W-1:0]    armed_ticks
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_FIN = 3'd3;

	localparam logic [twtc_pkg::CNT_W-1:0] CNT_LAST = {twtc_pkg::CNT_W{1'b1}};

	logic [2:0]                    state_q;
	logic [twtc_pkg::MODE_W-1:0]   mode_q;
	twtc_pkg::word_t               cpt_q;
	twtc_pkg::word_t               tick_irq_q;
	twtc_pkg::word_t               armed_q;
	twtc_pkg::word_t               req_q;
	twtc_pkg::word_t               comp_q;
	twtc_pkg::word_t               now_q;
	twtc_pkg::word_t               prod_q;
	twtc_pkg::word_t               qd_q;
	twtc_pkg::word_t               rem_q;
	logic [twtc_pkg::CNT_W-1:0]    cnt_q;
	logic                          out_valid_q;
	logic                          reload_valid_q;
	twtc_pkg::word_t               reload_cycles_q;
	twtc_pkg::word_t               ticks_q;
	twtc_pkg::word_t               armed_out_q;

	logic                          accept;
	logic                          fin_go;
	logic [twtc_pkg::MODE_W-1:0]   mode_d;
	twtc_pkg::word_t               comp_d;
	logic [twtc_pkg::DATA_W:0]     shifted;
	logic [twtc_pkg::DATA_W:0]     diff;
	logic                          ge;
	twtc_pkg::word_t               mul_a;
	twtc_pkg::word_t               mul_full;
	logic                          rv_d;
	twtc_pkg::word_t               rc_d;
	twtc_pkg::word_t               tk_d;
	twtc_pkg::word_t               arm_d;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		mode_d = twtc_pkg::MODE_NONE;
		unique case (req_type)
			twtc_pkg::REQ_START: begin
				if (cpt_q != '0 && sleep_request > twtc_pkg::word_t'(1)) begin
					mode_d = twtc_pkg::MODE_PLAN;
				end
			end
			twtc_pkg::REQ_WAKE: begin
				if (armed_q == '0) begin
					mode_d = twtc_pkg::MODE_NONE;
				end else if (irq_number == tick_irq_q || cpt_q == '0) begin
					mode_d = twtc_pkg::MODE_TICK;
				end else begin
					mode_d = twtc_pkg::MODE_EARLY;
				end
			end
			twtc_pkg::REQ_CANCEL: begin
				mode_d = twtc_pkg::MODE_CANCEL;
			end
			default: begin
				mode_d = twtc_pkg::MODE_NONE;
			end
		endcase
	end

	assign comp_d = (timer_before > timer_now) ? (timer_before - timer_now)
		: (cpt_q + timer_before - timer_now);

	assign shifted = {rem_q, qd_q[twtc_pkg::DATA_W-1]};
	assign ge = (shifted >= {1'b0, cpt_q});
	assign diff = shifted - {1'b0, cpt_q};

	assign mul_a = (mode_q == twtc_pkg::MODE_PLAN) ? req_q : armed_q;
	assign mul_full = mul_a * cpt_q;

	always_comb begin
		rv_d = 1'b0;
		rc_d = '0;
		tk_d = '0;
		arm_d = armed_q;
		case (mode_q)
			twtc_pkg::MODE_CANCEL: begin
				arm_d = '0;
			end
			twtc_pkg::MODE_TICK: begin
				tk_d = armed_q - twtc_pkg::word_t'(1);
				arm_d = '0;
			end
			twtc_pkg::MODE_PLAN: begin
				rv_d = 1'b1;
				rc_d = (prod_q > comp_q) ? (prod_q - comp_q) : cpt_q;
				arm_d = req_q;
			end
			twtc_pkg::MODE_EARLY: begin
				if (qd_q < armed_q) begin
					rv_d = 1'b1;
					rc_d = cpt_q - rem_q;
					tk_d = qd_q;
				end else begin
					tk_d = armed_q - twtc_pkg::word_t'(1);
				end
				arm_d = '0;
			end
			default: begin
				arm_d = armed_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= twtc_pkg::MODE_NONE;
			cpt_q <= '0;
			tick_irq_q <= twtc_pkg::ALL_ONES;
			armed_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					twtc_pkg::CFG_CYCLES_PER_TICK: cpt_q <= cfg_data;
					twtc_pkg::CFG_TICK_IRQ: tick_irq_q <= cfg_data;
					default: tick_irq_q <= tick_irq_q;
				endcase
			end
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= mode_d;
						cnt_q <= '0;
						if (mode_d == twtc_pkg::MODE_PLAN) begin
							state_q <= ST_DIV;
						end else if (mode_d == twtc_pkg::MODE_EARLY) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + twtc_pkg::CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= (mode_q == twtc_pkg::MODE_PLAN) ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					cnt_q <= '0;
					state_q <= (mode_q == twtc_pkg::MODE_PLAN) ? ST_FIN : ST_DIV;
				end
				ST_FIN: begin
					if (fin_go) begin
						armed_q <= arm_d;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= sleep_request;
			comp_q <= comp_d;
			now_q <= timer_now;
			qd_q <= twtc_pkg::ALL_ONES;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			qd_q <= {qd_q[twtc_pkg::DATA_W-2:0], ge};
			rem_q <= ge ? diff[twtc_pkg::DATA_W-1:0] : shifted[twtc_pkg::DATA_W-1:0];
			if (cnt_q == CNT_LAST && mode_q == twtc_pkg::MODE_PLAN) begin
				req_q <= (req_q >= {qd_q[twtc_pkg::DATA_W-2:0], ge})
					? {qd_q[twtc_pkg::DATA_W-2:0], ge} : req_q;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_full;
			if (mode_q == twtc_pkg::MODE_EARLY) begin
				qd_q <= mul_full - now_q;
				rem_q <= '0;
			end
		end
		if (fin_go) begin
			reload_valid_q <= rv_d;
			reload_cycles_q <= rc_d;
			ticks_q <= tk_d;
			armed_out_q <= arm_d;
		end
	end

	assign out_valid = out_valid_q;
	assign reload_valid = reload_valid_q;
	assign reload_cycles = reload_cycles_q;
	assign ticks_to_add = ticks_q;
	assign armed_ticks = armed_out_q;

	`TWTC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready,
		"input accepted again right after a beat")
	`TWTC_ASSERT_SAME(a_reload_nonzero, out_valid && reload_valid, reload_cycles != '0,
		"timer reload of zero cycles")
	`TWTC_ASSERT_SAME(a_credit_disarms, out_valid && ticks_to_add != '0, armed_ticks == '0,
		"ticks credited while a sleep stays armed")

endmodule

FILE: tb/tb_tickless_wakeup_timer_control_top.sv
// ----------------------------------------------------------------------------
// Testbench for the tickless wakeup timer control
// A directed table of register writes and beats runs first. A random run with
// several tick settings follows and is drawn mostly from starts and wakeups.
// Each result is checked field by field against a typed row or the model.
// ----------------------------------------------------------------------------
module tb_tickless_wakeup_timer_control_top;
	timeunit 1ns;
	timeprecision 1ps;

	import twtc_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned RAND_PHASES = 8;
	localparam int unsigned BEATS_PER_PHASE = 200;

	typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

	typedef struct {
		logic  reload_valid;
		word_t reload_cycles;
		word_t ticks_to_add;
		word_t armed_ticks;
	} outcome_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		word_t                 reg_val;
		logic [REQ_W-1:0]      req;
		word_t                 sleep_req;
		word_t                 t_before;
		word_t                 t_now;
		word_t                 irq;
		bit                    typed;
		outcome_t              want;
	} step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CYCLES_PER_TICK;
	word_t                cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [REQ_W-1:0]     req_type = REQ_START;
	word_t                sleep_request = '0;
	word_t                timer_before = '0;
	word_t                timer_now = '0;
	word_t                irq_number = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 reload_valid;
	word_t                reload_cycles;
	word_t                ticks_to_add;
	word_t                armed_ticks;

	word_t       cpt_model = '0;
	word_t       irq_model = ALL_ONES;
	word_t       armed_model = '0;
	outcome_t    outcomes_due[$];
	bit          beat_typed = 1'b0;
	outcome_t    beat_want;
	int unsigned beats_in = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	bit          calm = 1'b0;

	tickless_wakeup_timer_control_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.sleep_request(sleep_request),
		.timer_before(timer_before),
		.timer_now(timer_now),
		.irq_number(irq_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reload_valid(reload_valid),
		.reload_cycles(reload_cycles),
		.ticks_to_add(ticks_to_add),
		.armed_ticks(armed_ticks)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic outcome_t compute_timer_outcome(logic [REQ_W-1:0] rq, word_t sreq,
			word_t tb4, word_t tnow, word_t irq);
		outcome_t o;
		word_t    limit;
		word_t    ticks;
		word_t    cyc;
		word_t    comp;
		word_t    elapsed;
		word_t    whole;
		o = '{1'b0, '0, '0, '0};
		case (rq)
			REQ_START: begin
				if (cpt_model != '0 && sreq > 32'd1) begin
					limit = ALL_ONES / cpt_model;
					ticks = (sreq >= limit) ? limit : sreq;
					cyc = ticks * cpt_model;
					comp = (tb4 > tnow) ? tb4 - tnow : (cpt_model + tb4) - tnow;
					cyc = (cyc > comp) ? cyc - comp : cpt_model;
					o.reload_valid = 1'b1;
					o.reload_cycles = cyc;
					armed_model = ticks;
				end
			end
			REQ_WAKE: begin
				if (armed_model != '0) begin
					if (irq != irq_model && cpt_model != '0) begin
						elapsed = armed_model * cpt_model - tnow;
						whole = elapsed / cpt_model;
						if (whole < armed_model) begin
							o.ticks_to_add = whole;
							o.reload_valid = 1'b1;
							o.reload_cycles = cpt_model - (elapsed % cpt_model);
						end else begin
							o.ticks_to_add = armed_model - 32'd1;
						end
					end else begin
						o.ticks_to_add = armed_model - 32'd1;
					end
					armed_model = '0;
				end
			end
			REQ_CANCEL: begin
				armed_model = '0;
			end
			default: begin
			end
		endcase
		o.armed_ticks = armed_model;
		return o;
	endfunction

	function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, word_t val);
		step_t s;
		s = '{ROW_CFG, idx, val, REQ_UNUSED, '0, '0, '0, '0, 1'b0, '{1'b0, '0, '0, '0}};
		return s;
	endfunction

	function automatic step_t beat_row(logic [REQ_W-1:0] rq, word_t sreq, word_t tb4,
			word_t tnow, word_t irq);
		step_t s;
		s = '{ROW_BEAT, CFG_CYCLES_PER_TICK, '0, rq, sreq, tb4, tnow, irq, 1'b0,
			'{1'b0, '0, '0, '0}};
		return s;
	endfunction

	function automatic step_t typed_row(logic [REQ_W-1:0] rq, word_t sreq, word_t tb4,
			word_t tnow, word_t irq, logic rv, word_t rc, word_t ta, word_t at);
		step_t s;
		s = beat_row(rq, sreq, tb4, tnow, irq);
		s.typed = 1'b1;
		s.want = '{rv, rc, ta, at};
		return s;
	endfunction

	task automatic flag_mismatch(string what, word_t got, word_t want);
		mismatches++;
		$display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : watch_beats
		outcome_t w;
		outcome_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					flag_mismatch("result with nothing due", armed_ticks, '0);
				end else begin
					w = outcomes_due.pop_front();
					if (reload_valid !== w.reload_valid)
						flag_mismatch("reload_valid", 32'(reload_valid), 32'(w.reload_valid));
					if (reload_cycles !== w.reload_cycles)
						flag_mismatch("reload_cycles", reload_cycles, w.reload_cycles);
					if (ticks_to_add !== w.ticks_to_add)
						flag_mismatch("ticks_to_add", ticks_to_add, w.ticks_to_add);
					if (armed_ticks !== w.armed_ticks)
						flag_mismatch("armed_ticks", armed_ticks, w.armed_ticks);
				end
			end
			if (in_valid && in_ready) begin
				got = compute_timer_outcome(req_type, sleep_request, timer_before, timer_now,
					irq_number);
				outcomes_due.push_back(beat_typed ? beat_want : got);
				beats_in <= beats_in + 1;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 10);
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic wait_drained();
		in_valid = 1'b0;
		while (outcomes_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
		wait_drained();
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == CFG_CYCLES_PER_TICK)
			cpt_model = val;
		else
			irq_model = val;
	endtask

	task automatic drive_beat(step_t s);
		int unsigned seen;
		if (!calm && $urandom_range(0, 99) < 10) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_type = s.req;
		sleep_request = s.sleep_req;
		timer_before = s.t_before;
		timer_now = s.t_now;
		irq_number = s.irq;
		beat_typed = s.typed;
		beat_want = s.want;
		in_valid = 1'b1;
		seen = beats_in;
		do
			@(negedge clk);
		while (beats_in == seen);
	endtask

	function automatic step_t random_beat();
		step_t s;
		int    pick;
		pick = $urandom_range(0, 99);
		s = beat_row(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
		if (pick < 45) begin
			s.req = REQ_START;
			case ($urandom_range(0, 3))
				0: s.sleep_req = $urandom_range(0, 3);
				1: s.sleep_req = $urandom_range(2, 64);
				2: s.sleep_req = ALL_ONES;
				default: begin
				end
			endcase
			if ($urandom_range(0, 1) == 0)
				s.t_before = s.t_now + $urandom_range(0, 300);
		end else if (pick < 88) begin
			s.req = REQ_WAKE;
			case ($urandom_range(0, 2))
				0: s.irq = irq_model;
				1: s.irq = $urandom_range(0, 15);
				default: begin
				end
			endcase
			if (armed_model != '0 && cpt_model != '0 && $urandom_range(0, 3) != 0)
				s.t_now = $urandom_range(0, armed_model * cpt_model);
		end else if (pick < 94) begin
			s.req = REQ_CANCEL;
		end else if (pick >= 97) begin
			s.req = REQ_W'($urandom_range(0, 3));
		end
		return s;
	endfunction

	initial begin
		step_t directed_steps[$];
		word_t phase_cpt;
		word_t phase_irq;
		directed_steps = '{
			typed_row(REQ_START, 32'd100, '0, '0, '0, 1'b0, '0, '0, '0),
			typed_row(REQ_WAKE, '0, '0, '0, 32'd5, 1'b0, '0, '0, '0),
			typed_row(REQ_CANCEL, '0, '0, '0, '0, 1'b0, '0, '0, '0),
			typed_row(REQ_UNUSED, '0, '0, '0, '0, 1'b0, '0, '0, '0),
			cfg_row(CFG_CYCLES_PER_TICK, 32'd1000),
			cfg_row(CFG_TICK_IRQ, 32'd7),
			typed_row(REQ_START, '0, 32'd50, 32'd10, '0, 1'b0, '0, '0, '0),
			typed_row(REQ_START, 32'd1, 32'd50, 32'd10, '0, 1'b0, '0, '0, '0),
			typed_row(REQ_START, 32'd10, 32'd500, 32'd300, '0, 1'b1, 32'd9800, '0, 32'd10),
			typed_row(REQ_WAKE, '0, '0, '0, 32'd7, 1'b0, '0, 32'd9, '0),
			beat_row(REQ_START, ALL_ONES, '0, '0, '0),
			beat_row(REQ_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES),
			beat_row(REQ_WAKE, '0, '0, '0, 32'd3),
			beat_row(REQ_START, 32'd5, 32'd100, 32'd100, '0),
			beat_row(REQ_WAKE, '0, '0, 32'd2500, '0),
			beat_row(REQ_START, 32'd2, '0, ALL_ONES, '0),
			beat_row(REQ_CANCEL, '0, '0, '0, '0),
			beat_row(REQ_WAKE, '0, '0, '0, 32'd1),
			beat_row(REQ_START, 32'd3, ALL_ONES, '0, '0),
			beat_row(REQ_WAKE, '0, '0, ALL_ONES, ALL_ONES),
			cfg_row(CFG_CYCLES_PER_TICK, ALL_ONES),
			cfg_row(CFG_TICK_IRQ, ALL_ONES),
			beat_row(REQ_START, ALL_ONES, 32'd1, '0, '0),
			beat_row(REQ_WAKE, '0, '0, '0, ALL_ONES),
			cfg_row(CFG_CYCLES_PER_TICK, 32'd1),
			beat_row(REQ_START, ALL_ONES, '0, '0, '0),
			beat_row(REQ_WAKE, '0, '0, ALL_ONES, 32'd2),
			beat_row(REQ_START, 32'd4, 32'd10, 32'd9, '0),
			cfg_row(CFG_CYCLES_PER_TICK, '0),
			beat_row(REQ_WAKE, '0, '0, '0, 32'd9)
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == ROW_CFG)
				write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
			else
				drive_beat(directed_steps[i]);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin phase_cpt = 32'd1000; phase_irq = ALL_ONES; end
				1: begin phase_cpt = $urandom_range(2, 5000); phase_irq = $urandom_range(0, 15); end
				2: begin phase_cpt = 32'd1; phase_irq = '0; end
				3: begin phase_cpt = ALL_ONES; phase_irq = $urandom_range(0, 15); end
				4: begin phase_cpt = $urandom_range(2, 300); phase_irq = $urandom; end
				5: begin phase_cpt = $urandom; phase_irq = $urandom_range(0, 15); end
				6: begin phase_cpt = 32'h8000_0000 | $urandom; phase_irq = ALL_ONES; end
				default: begin phase_cpt = '0; phase_irq = $urandom; end
			endcase
			write_reg(CFG_CYCLES_PER_TICK, phase_cpt);
			write_reg(CFG_TICK_IRQ, phase_irq);
			calm = (p == 4);
			for (int n = 0; n < BEATS_PER_PHASE; n++)
				drive_beat(random_beat());
		end
		calm = 1'b0;

		wait_drained();
		repeat (40) @(negedge clk);
		if (outcomes_due.size() != 0)
			flag_mismatch("results never delivered", outcomes_due.size(), '0);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/twtc_pkg.sv
hdl/tickless_wakeup_timer_control_top.sv
tb/tb_tickless_wakeup_timer_control_top.sv
